@@ hw/rtl/cra_pkg.sv @@
// cra_pkg: shared constants, register indexes and sequencer states for the
// conductivity ratio averager; no dependencies
package cra_pkg;

  localparam int ADC_FIELD_W   = 12;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 31;
  localparam int COUNT_W       = 8;
  localparam int PAIR_W        = 9;
  localparam int OUT_W         = 32;
  localparam int RATIO_SCALE_W = 17;

  localparam logic [RATIO_SCALE_W-1:0] RATIO_SCALE = 17'd100000;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

  localparam logic [COUNT_W-1:0]    SAMPLE_COUNT_RESET   = 8'd10;
  localparam logic [CFG_DATA_W-1:0] HIGH_THRESHOLD_RESET = 31'd100000;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [6:0] {
    S_IN        = 7'b0000001,
    S_LOAD      = 7'b0000010,
    S_DIV_RATIO = 7'b0000100,
    S_ACCUM     = 7'b0001000,
    S_CHECK     = 7'b0010000,
    S_DIV_AVG   = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

endpackage

@@ hw/rtl/conductivity_ratio_averager_unit.sv @@
// conductivity_ratio_averager_unit: phase sums, bit-serial ratio divider,
// running ratio sum and final average; depends on cra_pkg
//
// channel   dir  payload                                      transfer
// s_*       in   tdata {current_adc, voltage_adc}, tuser start  tvalid & tready
// m_*       out  tdata mean_ratio, tuser {err, above}           tvalid & tready
// cfg_*     in   index + data, written when cfg_we is high       cfg_we
//
// an item that does not end a low phase is taken and the unit stays ready
// an item that ends the settling pair or a zero voltage difference pair skips the divider
// any other low phase end runs the ratio divider, one restoring divider step per cycle
// over the 41-bit accumulator width; no new item is taken until it finishes
// the last pair of a run also runs the average through the same divider
// a finished result sits in the output register; a following result waits
// until it is taken. reset is synchronous and returns the run to idle
module conductivity_ratio_averager_unit #(
  parameter int READINGS_PER_PHASE = 5,
  parameter int ADC_BITS           = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [2*cra_pkg::ADC_FIELD_W-1:0] s_tdata,  // voltage_adc, current_adc
  input  logic                            s_tuser,  // start_req
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cra_pkg::OUT_W-1:0]       m_tdata,  // mean_ratio
  output logic [1:0]                      m_tuser,  // above_threshold, divide_error
  input  logic                            cfg_we,
  input  logic [cra_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cra_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cra_pkg::*;

  localparam int SUM_W = ADC_BITS + $clog2(READINGS_PER_PHASE);
  localparam int DIFF_W = SUM_W + 1;
  localparam int NUM_W = SUM_W + RATIO_SCALE_W;
  localparam int ACC_W = NUM_W + COUNT_W + 1;
  localparam int DVR_W = (SUM_W > COUNT_W) ? SUM_W : COUNT_W;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int IDX_W = $clog2(READINGS_PER_PHASE + 1);
  localparam logic [ADC_FIELD_W-1:0] ADC_MASK = (ADC_BITS >= ADC_FIELD_W) ?
    {ADC_FIELD_W{1'b1}} : ADC_FIELD_W'((1 << ADC_BITS) - 1);

  state_t state, state_next;

  logic [COUNT_W-1:0]    sample_count;
  logic [CFG_DATA_W-1:0] high_threshold;

  logic [IDX_W-1:0]  reading_index, reading_index_next;
  logic              phase_low, phase_low_next;
  logic [SUM_W-1:0]  voltage_phase_sum, voltage_phase_sum_next;
  logic [SUM_W-1:0]  current_phase_sum, current_phase_sum_next;
  logic [SUM_W-1:0]  voltage_high_value, voltage_high_value_next;
  logic [SUM_W-1:0]  current_high_value, current_high_value_next;
  logic [PAIR_W-1:0] pair_counter, pair_counter_next;
  logic signed [ACC_W-1:0] ratio_sum, ratio_sum_next;
  logic              error_seen, error_seen_next;
  logic              running, running_next;

  logic [SUM_W-1:0]  cd_mag, cd_mag_next;
  logic [ACC_W-1:0]  div_shift, div_shift_next;
  logic [DVR_W-1:0]  divisor, divisor_next;
  logic [DVR_W-1:0]  rem, rem_next;
  logic [CNT_W-1:0]  div_cnt, div_cnt_next;
  logic              q_neg, q_neg_next;

  logic              m_tvalid_next;
  logic [OUT_W-1:0]  m_tdata_next;
  logic [1:0]        m_tuser_next;

  logic [ADC_FIELD_W-1:0] v_in, c_in;
  logic [DVR_W:0]    rem_try, rem_sub;
  logic              fits;
  logic [NUM_W-1:0]  product;
  logic [COUNT_W-1:0] count;
  logic [ACC_W-1:0]  q_signed;
  logic [ACC_W-1:0]  sum_mag;

  // per-item working values
  logic [IDX_W-1:0]  idx_w;
  logic              ph_w;
  logic [SUM_W-1:0]  vs_w, cs_w, vh_w, ch_w;
  logic [PAIR_W-1:0] pc_w;
  logic signed [DIFF_W-1:0] vd, cd;
  logic [DIFF_W-1:0] vd_abs, cd_abs;

  assign v_in = s_tdata[ADC_FIELD_W-1:0] & ADC_MASK;
  assign c_in = s_tdata[2*ADC_FIELD_W-1:ADC_FIELD_W] & ADC_MASK;
  assign s_tready = (state == S_IN);

  // one restoring division step
  assign rem_try = {rem, div_shift[ACC_W-1]};
  assign rem_sub = rem_try - {1'b0, divisor};
  assign fits = (rem_try >= {1'b0, divisor});

  assign product = NUM_W'(cd_mag) * NUM_W'(RATIO_SCALE);
  assign count = (sample_count == '0) ? COUNT_W'(1) : sample_count;
  assign q_signed = q_neg ? (~div_shift + ACC_W'(1)) : div_shift;
  assign sum_mag = ratio_sum[ACC_W-1] ? ACC_W'(-ratio_sum) : ACC_W'(ratio_sum);

  always_comb begin
    state_next = state;
    reading_index_next = reading_index;
    phase_low_next = phase_low;
    voltage_phase_sum_next = voltage_phase_sum;
    current_phase_sum_next = current_phase_sum;
    voltage_high_value_next = voltage_high_value;
    current_high_value_next = current_high_value;
    pair_counter_next = pair_counter;
    ratio_sum_next = ratio_sum;
    error_seen_next = error_seen;
    running_next = running;
    cd_mag_next = cd_mag;
    div_shift_next = div_shift;
    divisor_next = divisor;
    rem_next = rem;
    div_cnt_next = div_cnt;
    q_neg_next = q_neg;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next = m_tdata;
    m_tuser_next = m_tuser;

    idx_w = reading_index;
    ph_w = phase_low;
    vs_w = voltage_phase_sum;
    cs_w = current_phase_sum;
    vh_w = voltage_high_value;
    ch_w = current_high_value;
    pc_w = pair_counter;
    vd = '0;
    cd = '0;
    vd_abs = '0;
    cd_abs = '0;

    unique case (state) inside
      S_IN: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            idx_w = '0;
            ph_w = 1'b0;
            vs_w = '0;
            cs_w = '0;
            vh_w = '0;
            ch_w = '0;
            pc_w = '0;
            ratio_sum_next = '0;
            error_seen_next = 1'b0;
            running_next = 1'b1;
          end
          if (s_tuser || running) begin
            vs_w = vs_w + SUM_W'(v_in);
            cs_w = cs_w + SUM_W'(c_in);
            idx_w = idx_w + IDX_W'(1);
            if (idx_w == IDX_W'(READINGS_PER_PHASE)) begin
              idx_w = '0;
              if (!ph_w) begin
                vh_w = vs_w;
                ch_w = cs_w;
                vs_w = '0;
                cs_w = '0;
                ph_w = 1'b1;
              end else begin
                vd = $signed({1'b0, vh_w}) - $signed({1'b0, vs_w});
                cd = $signed({1'b0, ch_w}) - $signed({1'b0, cs_w});
                vd_abs = vd[DIFF_W-1] ? DIFF_W'(-vd) : DIFF_W'(vd);
                cd_abs = cd[DIFF_W-1] ? DIFF_W'(-cd) : DIFF_W'(cd);
                vs_w = '0;
                cs_w = '0;
                ph_w = 1'b0;
                state_next = S_CHECK;
                if (pc_w != '0) begin
                  if (vd == '0) begin
                    error_seen_next = 1'b1;
                  end else begin
                    cd_mag_next = cd_abs[SUM_W-1:0];
                    divisor_next = DVR_W'(vd_abs[SUM_W-1:0]);
                    q_neg_next = vd[DIFF_W-1] ^ cd[DIFF_W-1];
                    state_next = S_LOAD;
                  end
                end
                pc_w = pc_w + PAIR_W'(1);
              end
            end
          end
          reading_index_next = idx_w;
          phase_low_next = ph_w;
          voltage_phase_sum_next = vs_w;
          current_phase_sum_next = cs_w;
          voltage_high_value_next = vh_w;
          current_high_value_next = ch_w;
          pair_counter_next = pc_w;
        end
      end
      S_LOAD: begin
        div_shift_next = ACC_W'(product);
        rem_next = '0;
        div_cnt_next = CNT_W'(ACC_W);
        state_next = S_DIV_RATIO;
      end
      S_DIV_RATIO, S_DIV_AVG: begin
        rem_next = fits ? rem_sub[DVR_W-1:0] : rem_try[DVR_W-1:0];
        div_shift_next = {div_shift[ACC_W-2:0], fits};
        div_cnt_next = div_cnt - CNT_W'(1);
        if (div_cnt == CNT_W'(1)) begin
          state_next = (state == S_DIV_RATIO) ? S_ACCUM : S_DONE;
        end
      end
      S_ACCUM: begin
        ratio_sum_next = ratio_sum + $signed(q_signed);
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (pair_counter >= PAIR_W'(count) + PAIR_W'(1)) begin
          div_shift_next = sum_mag;
          divisor_next = DVR_W'(count);
          q_neg_next = ratio_sum[ACC_W-1];
          rem_next = '0;
          div_cnt_next = CNT_W'(ACC_W);
          state_next = S_DIV_AVG;
        end else begin
          state_next = S_IN;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          if (!q_neg && div_shift > ACC_W'(SAT_POS)) begin
            m_tdata_next = SAT_POS;
          end else if (q_neg && div_shift > ACC_W'(SAT_NEG)) begin
            m_tdata_next = SAT_NEG;
          end else begin
            m_tdata_next = q_signed[OUT_W-1:0];
          end
          m_tuser_next = {error_seen,
                          !q_neg && (div_shift > ACC_W'(high_threshold))};
          m_tvalid_next = 1'b1;
          reading_index_next = '0;
          phase_low_next = 1'b0;
          voltage_phase_sum_next = '0;
          current_phase_sum_next = '0;
          voltage_high_value_next = '0;
          current_high_value_next = '0;
          pair_counter_next = '0;
          ratio_sum_next = '0;
          error_seen_next = 1'b0;
          running_next = 1'b0;
          state_next = S_IN;
        end
      end
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      sample_count <= SAMPLE_COUNT_RESET;
      high_threshold <= HIGH_THRESHOLD_RESET;
      reading_index <= '0;
      phase_low <= 1'b0;
      voltage_phase_sum <= '0;
      current_phase_sum <= '0;
      voltage_high_value <= '0;
      current_high_value <= '0;
      pair_counter <= '0;
      ratio_sum <= '0;
      error_seen <= 1'b0;
      running <= 1'b0;
      div_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_COUNT:   sample_count <= cfg_data[COUNT_W-1:0];
          REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
          default: ;
        endcase
      end
      reading_index <= reading_index_next;
      phase_low <= phase_low_next;
      voltage_phase_sum <= voltage_phase_sum_next;
      current_phase_sum <= current_phase_sum_next;
      voltage_high_value <= voltage_high_value_next;
      current_high_value <= current_high_value_next;
      pair_counter <= pair_counter_next;
      ratio_sum <= ratio_sum_next;
      error_seen <= error_seen_next;
      running <= running_next;
      div_cnt <= div_cnt_next;
      m_tvalid <= m_tvalid_next;
    end
    cd_mag <= cd_mag_next;
    div_shift <= div_shift_next;
    divisor <= divisor_next;
    rem <= rem_next;
    q_neg <= q_neg_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
  end

  a_div_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_RATIO || state == S_DIV_AVG) |-> div_cnt != '0)
    else $error("divider running with an empty step count");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    reading_index < IDX_W'(READINGS_PER_PHASE))
    else $error("reading index out of range");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    pair_counter <= PAIR_W'(256))
    else $error("pair counter past the longest run");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result loaded outside the completion state");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> !running && state == S_IN)
    else $error("run not closed after its result");

endmodule

@@ tb/tb_conductivity_ratio_averager_unit.sv @@
// tb_conductivity_ratio_averager_unit: self-checking bench for the conductivity ratio averager;
// streams adc pairs with random gaps and output stalls and checks every result against a
// predictor of the phase sums and ratio average; depends on cra_pkg and the unit rtl
module tb_conductivity_ratio_averager_unit;
  import cra_pkg::*;

  localparam int PHASE_LEN      = 5;
  localparam int SCALE          = 100000;
  localparam int IDLE_WAIT      = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SET_ITEMS      = 50;
  localparam int NUM_SETS       = 12;
  localparam int STALL_W        = 12;
  localparam longint AVG_MAX    = 64'sd2147483647;
  localparam longint AVG_MIN    = -64'sd2147483648;

  typedef enum int {PAIR_SPREAD, PAIR_FLAT, PAIR_NARROW} pair_kind_t;

  typedef struct {
    bit        start;
    bit [11:0] volt;
    bit [11:0] curr;
  } adc_pair_t;

  typedef struct {
    bit signed [31:0] avg;
    bit               above;
    bit               err;
  } avg_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [2*ADC_FIELD_W-1:0] s_tdata = '0;  // voltage_adc, current_adc
  logic                   s_tuser = 1'b0;  // start_req
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_W-1:0]       m_tdata;         // mean_ratio
  logic [1:0]             m_tuser;         // above_threshold, divide_error
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  conductivity_ratio_averager_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit [7:0]  cnt_cfg = SAMPLE_COUNT_RESET;
  bit [30:0] thr_cfg = HIGH_THRESHOLD_RESET;
  bit [2:0]  rd_idx;
  bit        in_low;
  bit [14:0] v_sum, c_sum;
  bit [15:0] v_high, c_high;
  bit [8:0]  pairs_done;
  longint    ratio_acc;
  bit        err_seen;
  bit        run_active;

  adc_pair_t   adc_feed_q[$];
  avg_result_t pending_averages[$];
  adc_pair_t   in_flight;
  avg_result_t want_avg;
  int          mismatch_count;
  int          fed_items;
  int          burst_left, gap_left;
  bit          tx_calm, rx_calm;
  bit [STALL_W-1:0] stall_pat = '1;
  int          quiet_cycles;

  task automatic clear_run();
    rd_idx = '0;
    in_low = 1'b0;
    v_sum = '0;
    c_sum = '0;
    v_high = '0;
    c_high = '0;
    pairs_done = '0;
    ratio_acc = 0;
    err_seen = 1'b0;
  endtask

  task automatic accumulate_ratio(input adc_pair_t p);
    longint vd, cd, avg;
    int unsigned cnt;
    avg_result_t r;
    if (p.start) begin
      clear_run();
      run_active = 1'b1;
    end
    if (!run_active) return;
    v_sum += p.volt;
    c_sum += p.curr;
    rd_idx++;
    if (rd_idx < PHASE_LEN) return;
    rd_idx = '0;
    if (!in_low) begin
      v_high = {v_sum, 1'b0};
      c_high = {c_sum, 1'b0};
      v_sum = '0;
      c_sum = '0;
      in_low = 1'b1;
      return;
    end
    vd = longint'(v_high) - 2 * longint'(v_sum);
    cd = longint'(c_high) - 2 * longint'(c_sum);
    v_sum = '0;
    c_sum = '0;
    in_low = 1'b0;
    // settling pair is dropped
    if (pairs_done != 0) begin
      if (vd == 0) err_seen = 1'b1;
      else ratio_acc += (cd * SCALE) / vd;
    end
    pairs_done++;
    cnt = (cnt_cfg == 0) ? 1 : cnt_cfg;
    if (pairs_done < cnt + 1) return;
    avg = ratio_acc / longint'(cnt);
    if (avg > AVG_MAX) avg = AVG_MAX;
    if (avg < AVG_MIN) avg = AVG_MIN;
    r.avg = avg[31:0];
    r.above = avg > longint'(thr_cfg);
    r.err = err_seen;
    pending_averages.push_back(r);
    clear_run();
    run_active = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) accumulate_ratio(in_flight);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (adc_feed_q.size() != 0) begin
          in_flight = adc_feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {in_flight.curr, in_flight.volt};
          s_tuser <= in_flight.start;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= tx_calm ? 0 : $urandom_range(1, 9);
            tx_calm <= ($urandom_range(0, 3) == 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, reloaded now and then
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= stall_pat[0] | rx_calm;
      if (m_tvalid && m_tready && $urandom_range(0, 2) == 0) begin
        stall_pat <= STALL_W'($urandom()) | STALL_W'(1);
        rx_calm <= ($urandom_range(0, 3) == 0);
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[STALL_W-1:1]};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("unexpected result", $signed(m_tdata), 0);
      end else begin
        want_avg = pending_averages.pop_front();
        if (m_tdata !== want_avg.avg)
          report_mismatch("mean_ratio", $signed(m_tdata), want_avg.avg);
        if (m_tuser[0] !== want_avg.above)
          report_mismatch("above_threshold", m_tuser[0], want_avg.above);
        if (m_tuser[1] !== want_avg.err)
          report_mismatch("divide_error", m_tuser[1], want_avg.err);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("conductivity_ratio_averager_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_reading(input bit start, input bit [11:0] v, input bit [11:0] c);
    adc_pair_t p;
    p.start = start;
    p.volt = v;
    p.curr = c;
    adc_feed_q.push_back(p);
    fed_items++;
  endtask

  task automatic push_phase(input bit start, input bit [11:0] v, input bit [11:0] c);
    for (int k = 0; k < PHASE_LEN; k++) push_reading(start && k == 0, v, c);
  endtask

  task automatic push_pair(input bit start, input pair_kind_t kind);
    bit [11:0] hv[PHASE_LEN];
    bit [11:0] v;
    for (int k = 0; k < PHASE_LEN; k++) begin
      hv[k] = 12'($urandom_range(0, 4095));
      push_reading(start && k == 0, hv[k], 12'($urandom_range(0, 4095)));
    end
    for (int k = 0; k < PHASE_LEN; k++) begin
      case (kind)
        PAIR_FLAT: v = hv[k];
        // smallest nonzero voltage difference
        PAIR_NARROW: v = (k != 0) ? hv[k] : (hv[k] == 0 ? 12'd1 : hv[k] - 12'd1);
        default: v = 12'($urandom_range(0, 4095));
      endcase
      push_reading(1'b0, v, 12'($urandom_range(0, 4095)));
    end
  endtask

  task automatic push_run(input int pair_total);
    int pick;
    pair_kind_t kind;
    for (int p = 0; p < pair_total; p++) begin
      pick = $urandom_range(0, 9);
      kind = (pick == 0) ? PAIR_FLAT : (pick == 1) ? PAIR_NARROW : PAIR_SPREAD;
      push_pair(p == 0, kind);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SAMPLE_COUNT) cnt_cfg = val[7:0];
    else thr_cfg = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (adc_feed_q.size() != 0 || s_tvalid || pending_averages.size() != 0);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  initial begin
    int set_counts[NUM_SETS] = '{1, 2, 0, 3, 4, 1, 2, 3, 4, 1, 2, 110};
    int cnt;
    int set_start;
    int abort_len;
    bit [30:0] thr;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero count acts as one; threshold just under the first average
    write_reg(REG_SAMPLE_COUNT, '0);
    write_reg(REG_HIGH_THRESHOLD, 31'd99999);
    push_reading(1'b0, 12'd4095, 12'd4095);
    push_phase(1'b1, 12'd0, 12'd0);
    push_phase(1'b0, 12'd0, 12'd0);
    push_phase(1'b0, 12'd4095, 12'd4095);
    push_phase(1'b0, 12'd0, 12'd0);
    // restart in the middle of a high phase
    push_reading(1'b1, 12'd4095, 12'd0);
    push_reading(1'b0, 12'd4095, 12'd0);
    push_reading(1'b0, 12'd4095, 12'd0);
    push_phase(1'b1, 12'd0, 12'd4095);
    push_phase(1'b0, 12'd4095, 12'd0);
    // equal voltage phases
    push_phase(1'b0, 12'd2048, 12'd100);
    push_phase(1'b0, 12'd2048, 12'd3000);
    wait_drained();

    for (int s = 0; s < NUM_SETS; s++) begin
      case (s % 5)
        0: thr = '0;
        1: thr = 31'h7fff_ffff;
        2: thr = 31'($urandom_range(0, 150000));
        3: thr = HIGH_THRESHOLD_RESET;
        default: thr = 31'($urandom());
      endcase
      cnt = set_counts[s];
      write_reg(REG_HIGH_THRESHOLD, thr);
      // upper data bits are don't-care for the count register
      write_reg(REG_SAMPLE_COUNT, {($urandom_range(0, 1) ? 23'($urandom()) : 23'd0), 8'(cnt)});
      if (cnt == 0) cnt = 1;
      set_start = fed_items;
      do begin
        if ($urandom_range(0, 5) == 0) begin
          // aborted run, then a full one
          abort_len = $urandom_range(1, (cnt + 1) * 2 * PHASE_LEN - 1);
          for (int k = 0; k < abort_len; k++)
            push_reading(k == 0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
          adc_feed_q[adc_feed_q.size() - 1].start = ($urandom_range(0, 1) == 0);
        end
        push_run(cnt + 1);
        // ignored while idle
        repeat ($urandom_range(0, 2))
          push_reading(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end while (cnt < 255 && fed_items - set_start < SET_ITEMS);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("conductivity_ratio_averager_unit test passed");
    end else begin
      $display("conductivity_ratio_averager_unit test failed");
    end
    $finish;
  end

endmodule

@@ conductivity_ratio_averager_unit.f @@
hw/rtl/cra_pkg.sv
hw/rtl/conductivity_ratio_averager_unit.sv
tb/tb_conductivity_ratio_averager_unit.sv
